// ----- hw/rtl/gpu_batch_command_validator_macros.svh -----
// Assertion macros shared by the command validator RTL.
`ifndef GPU_BATCH_COMMAND_VALIDATOR_MACROS_SVH
`define GPU_BATCH_COMMAND_VALIDATOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define GBCV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GBCV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gbcv_pkg.sv -----
// Package: types, codes and decode helpers of the command validator.
package gbcv_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned ERR_W   = 3;

  localparam logic [WORD_W-1:0] END_WORD  = 32'h0500_0000;
  localparam logic [WORD_W-1:0] FENCE_TOP = 32'h6800_0000;
  localparam logic [WORD_W-1:0] TOP_MASK  = 32'hffff_0000;

  localparam logic [2:0] TYPE_MI   = 3'd0;
  localparam logic [2:0] TYPE_3D   = 3'd3;
  localparam logic [5:0] OP_NOOP   = 6'd0;
  localparam logic [5:0] OP_END    = 6'd10;
  localparam logic [5:0] OP_VAR_A  = 6'd32;
  localparam logic [5:0] OP_VAR_B  = 6'd36;
  localparam logic [5:0] OP_VAR_C  = 6'd38;
  localparam logic [5:0] OP_VAR_D  = 6'd46;

  localparam logic [ERR_W-1:0] ERR_OK           = 3'd0;
  localparam logic [ERR_W-1:0] ERR_HEADER       = 3'd1;
  localparam logic [ERR_W-1:0] ERR_END_NOT_LAST = 3'd2;
  localparam logic [ERR_W-1:0] ERR_TRUNCATED    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_END_WORD     = 3'd4;
  localparam logic [ERR_W-1:0] ERR_PADDING      = 3'd5;
  localparam logic [ERR_W-1:0] ERR_EMPTY        = 3'd6;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Classified word as it leaves the front end
  typedef struct packed {
    logic [LEN_W-1:0] hdr_len;   // 0 = bad header
    logic             end_op;
    logic             end_word;
    logic             nonzero;
    logic             pad;
    logic             last;
  } item_t;

  function automatic logic [LEN_W-1:0] header_len(input logic [WORD_W-1:0] w);
    logic [2:0] typ;
    logic [5:0] op;
    logic [LEN_W-1:0] len;
    typ = w[31:29];
    op  = w[28:23];
    len = '0;
    if (typ == TYPE_MI) begin
      if (op == OP_NOOP || op == OP_END) begin
        len = LEN_W'(1);
      end else if (op == OP_VAR_A || op == OP_VAR_B || op == OP_VAR_C || op == OP_VAR_D) begin
        len = {{(LEN_W-6){1'b0}}, w[5:0]} + LEN_W'(2);
      end
    end else if ((w & TOP_MASK) == FENCE_TOP) begin
      len = LEN_W'(1);
    end else if (typ == TYPE_3D) begin
      len = {{(LEN_W-12){1'b0}}, w[11:0]} + LEN_W'(2);
    end
    return len;
  endfunction

  // Keep only the first error
  function automatic logic [ERR_W-1:0] flag_err(input logic [ERR_W-1:0] cur,
                                                 input logic [ERR_W-1:0] code);
    return (cur == ERR_OK) ? code : cur;
  endfunction

  // End-of-used-region checks
  function automatic logic [ERR_W-1:0] close_region(input logic [ERR_W-1:0] cur,
                                                     input logic             any_used,
                                                     input logic [LEN_W-1:0] words_left,
                                                     input logic             last_end);
    logic [ERR_W-1:0] e;
    e = cur;
    if (!any_used) begin
      e = flag_err(e, ERR_EMPTY);
    end else begin
      if (words_left != '0) e = flag_err(e, ERR_TRUNCATED);
      if (!last_end) e = flag_err(e, ERR_END_WORD);
    end
    return e;
  endfunction

endpackage

// ----- hw/rtl/gbcv_front.sv -----
// Front end: accepts command words and classifies them for the walker.
module gbcv_front (
  input  logic [gbcv_pkg::WORD_W-1:0] in_cmd_word,
  input  logic                        in_padding,
  input  logic                        in_last_word,
  input  logic                        in_valid,
  output logic                        in_ready,
  output logic                        push_valid,
  input  logic                        push_ready,
  output gbcv_pkg::item_t             push_item
);
  import gbcv_pkg::*;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_item.hdr_len  = header_len(in_cmd_word);
    push_item.end_op   = (in_cmd_word[31:29] == TYPE_MI) && (in_cmd_word[28:23] == OP_END);
    push_item.end_word = (in_cmd_word == END_WORD);
    push_item.nonzero  = (in_cmd_word != '0);
    push_item.pad      = in_padding;
    push_item.last     = in_last_word;
  end

endmodule

// ----- hw/rtl/gbcv_queue.sv -----
// Short register queue between the front end and the walker.
`include "gpu_batch_command_validator_macros.svh"
module gbcv_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  gbcv_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output gbcv_pkg::item_t pop_item
);
  import gbcv_pkg::*;

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + QCNT_W'(1);
    else if (pop && !push) count_nxt = count_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  `GBCV_ASSERT_NOW(a_q_count_range, clk, rst_n, 1'b1, count_r <= QCNT_W'(QDEPTH), "queue overfull")
  `GBCV_ASSERT_NEXT(a_q_push_only_grows, clk, rst_n, push && !pop, count_r == $past(count_r) + QCNT_W'(1), "queue count lost a push")

endmodule

// ----- hw/rtl/gbcv_back.sv -----
// Back end: packet walker, sticky error tracking and result register.
`include "gpu_batch_command_validator_macros.svh"
module gbcv_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  gbcv_pkg::item_t             pop_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_header,
  output logic [gbcv_pkg::LEN_W-1:0]  out_packet_words,
  output logic [gbcv_pkg::ERR_W-1:0]  out_error_code,
  output logic                        out_batch_done,
  output logic                        out_batch_ok
);
  import gbcv_pkg::*;

  // walker state
  logic [LEN_W-1:0] words_left_r, words_left_nxt;
  logic [ERR_W-1:0] err_r, err_nxt;
  logic             end_seen_r, end_seen_nxt;
  logic             last_end_r, last_end_nxt;   // last used word == END_WORD
  logic             any_used_r, any_used_nxt;
  logic             pad_started_r, pad_started_nxt;

  // result register
  logic             out_valid_r;
  logic             is_header_r, is_header_nxt;
  logic [LEN_W-1:0] pkt_r, pkt_nxt;
  logic [ERR_W-1:0] err_out_r;
  logic             done_r, ok_r;

  logic             pop;

  assign pop_ready = !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    err_nxt         = err_r;
    words_left_nxt  = words_left_r;
    end_seen_nxt    = end_seen_r;
    any_used_nxt    = any_used_r;
    last_end_nxt    = last_end_r;
    pad_started_nxt = pad_started_r;
    is_header_nxt   = 1'b0;
    pkt_nxt         = '0;
    if (pop_item.pad || pad_started_r) begin
      if (!pad_started_r) begin
        err_nxt         = close_region(err_nxt, any_used_r, words_left_r, last_end_r);
        pad_started_nxt = 1'b1;
      end
      if (pop_item.nonzero) err_nxt = flag_err(err_nxt, ERR_PADDING);
    end else begin
      if (end_seen_r) err_nxt = flag_err(err_nxt, ERR_END_NOT_LAST);
      if (words_left_r != '0) begin
        words_left_nxt = words_left_r - LEN_W'(1);
      end else if (pop_item.hdr_len == '0) begin
        err_nxt = flag_err(err_nxt, ERR_HEADER);
      end else begin
        is_header_nxt  = 1'b1;
        pkt_nxt        = pop_item.hdr_len;
        words_left_nxt = pop_item.hdr_len - LEN_W'(1);
        if (pop_item.end_op) end_seen_nxt = 1'b1;
      end
      any_used_nxt = 1'b1;
      last_end_nxt = pop_item.end_word;
    end
    // final word with no padding closes the region here
    if (pop_item.last && !pad_started_nxt) begin
      err_nxt = close_region(err_nxt, any_used_nxt, words_left_nxt, last_end_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      words_left_r  <= '0;
      err_r         <= ERR_OK;
      end_seen_r    <= 1'b0;
      last_end_r    <= 1'b0;
      any_used_r    <= 1'b0;
      pad_started_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        if (pop_item.last) begin
          // next word opens a new batch
          words_left_r  <= '0;
          err_r         <= ERR_OK;
          end_seen_r    <= 1'b0;
          last_end_r    <= 1'b0;
          any_used_r    <= 1'b0;
          pad_started_r <= 1'b0;
        end else begin
          words_left_r  <= words_left_nxt;
          err_r         <= err_nxt;
          end_seen_r    <= end_seen_nxt;
          last_end_r    <= last_end_nxt;
          any_used_r    <= any_used_nxt;
          pad_started_r <= pad_started_nxt;
        end
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      is_header_r <= is_header_nxt;
      pkt_r       <= pkt_nxt;
      err_out_r   <= err_nxt;
      done_r      <= pop_item.last;
      ok_r        <= pop_item.last && (err_nxt == ERR_OK);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_is_header    = is_header_r;
  assign out_packet_words = pkt_r;
  assign out_error_code   = err_out_r;
  assign out_batch_done   = done_r;
  assign out_batch_ok     = ok_r;

  `GBCV_ASSERT_NOW(a_ok_implies_clean, clk, rst_n, out_valid_r && ok_r, done_r && err_out_r == ERR_OK, "batch_ok without clean finish")
  `GBCV_ASSERT_NOW(a_len_only_on_header, clk, rst_n, out_valid_r && !is_header_r, pkt_r == '0, "packet_words on non-header")
  `GBCV_ASSERT_NEXT(a_state_cleared_after_last, clk, rst_n, pop && pop_item.last, words_left_r == '0 && err_r == ERR_OK && !pad_started_r && !any_used_r, "state not cleared after final word")

endmodule

// ----- hw/rtl/gpu_batch_command_validator.sv -----
// Path: an accepted word is written into the 2-entry queue, then popped into the result register
//   that drives out_*.
// Throughput: one beat per cycle sustained while out_ready stays high; the walker state updates once per popped word.
// Reset: synchronous active-low rst_n empties the queue and result register and clears all
//   walker state; state also returns to reset after the final word of each batch.
// Top level of the command batch validator: front decode, queue, back walker.
module gpu_batch_command_validator (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel: one command word per beat
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gbcv_pkg::WORD_W-1:0] in_cmd_word,
  input  logic                        in_padding,
  input  logic                        in_last_word,
  // result channel: one result per word
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_is_header,
  output logic [gbcv_pkg::LEN_W-1:0]  out_packet_words,
  output logic [gbcv_pkg::ERR_W-1:0]  out_error_code,
  output logic                        out_batch_done,
  output logic                        out_batch_ok
);
  import gbcv_pkg::*;

  // front -> queue
  logic  push_valid, push_ready;
  item_t push_item;
  // queue -> back
  logic  pop_valid, pop_ready;
  item_t pop_item;

  // Header decode and word classification are stateless, so they sit
  // ahead of the queue; only the walker needs the running state.
  gbcv_front u_front (
    .in_cmd_word (in_cmd_word),
    .in_padding  (in_padding),
    .in_last_word(in_last_word),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  // Two entries: input keeps flowing one beat per cycle while out_ready is high,
  // beats queue up while a result waits on it, and in_ready stays off the output path.
  gbcv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  // Walker: packet lengths, sticky first error, end-of-region checks,
  // and the registered result beat.
  gbcv_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_item        (pop_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_header   (out_is_header),
    .out_packet_words(out_packet_words),
    .out_error_code  (out_error_code),
    .out_batch_done  (out_batch_done),
    .out_batch_ok    (out_batch_ok)
  );

endmodule
